// ===== hw/rtl/scs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants for the shared countdown scheduler.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int MAX_ENTRIES  = 16;
    localparam int ACTIVITY_MAX = 7;

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int TIME_W = 63;
    localparam int ID_W   = 32;
    localparam int WAIT_W = 5;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic [1:0] K_ADD  = 2'd0;
    localparam logic [1:0] K_BOOK = 2'd1;
    localparam logic [1:0] K_NEXT = 2'd2;
    localparam logic [1:0] K_TICK = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_REJ  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   entry_id;
        logic [TIME_W-1:0] duration;
        logic              bad;      // rejected on fields alone
    } t_cmd;

    typedef struct packed {
        logic [1:0]        status;
        logic [TIME_W-1:0] step_secs;
        logic [TIME_W-1:0] world_time;
        logic [WAIT_W-1:0] idle_cnt;
        logic              completed_valid;
        logic [ID_W-1:0]   completed_id;
        logic              last;
    } t_res;

endpackage

// ===== hw/rtl/scs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_front
// Accepts items, flags field-only rejects, and queues commands (two deep).
// ----------------------------------------------------------------------------
module scs_front import scs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_kind,
    input  logic [ID_W-1:0]   i_entry_id,
    input  logic [2:0]        i_activity,
    input  logic [TIME_W-1:0] i_duration,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_take
);

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_cmd.kind     = i_kind;
        w_cmd.entry_id = i_entry_id;
        w_cmd.duration = i_duration;
        case (i_kind)
            K_BOOK: w_cmd.bad = (i_activity == 3'd0) ||
                                (i_activity > 3'(ACTIVITY_MAX)) ||
                                (i_duration == '0);
            K_TICK: w_cmd.bad = (i_duration == '0);
            default: w_cmd.bad = 1'b0;
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign w_push      = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rd];
    assign w_pop       = o_cmd_valid && i_cmd_take;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ===== hw/rtl/scs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_back
// Entry table and sequencer: scans one entry per cycle for insert, book,
// minimum search and countdown update, held by a full result queue; emits results.
// ----------------------------------------------------------------------------
module scs_back import scs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_take,
    output logic o_res_valid,
    output t_res o_res,
    input  logic i_res_ready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_FLUSH  = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [ID_W-1:0]   r_ids [MAX_ENTRIES];
    logic [TIME_W-1:0] r_rem [MAX_ENTRIES];
    logic              r_arm [MAX_ENTRIES];
    logic [CNT_W-1:0]  r_count;
    logic [TIME_W-1:0] r_world;

    logic [2:0]        r_state;
    t_cmd              r_cmd;
    logic [CNT_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_slot;
    logic [CNT_W-1:0]  r_wait;
    logic [TIME_W-1:0] r_min;
    logic [1:0]        r_status;
    logic [WAIT_W-1:0] r_wcnt;
    logic              r_pend;
    logic [ID_W-1:0]   r_pid;

    logic [IDX_W-1:0]  w_ix;
    logic [ID_W-1:0]   w_eid;
    logic [TIME_W-1:0] w_erem;
    logic              w_earm;
    logic              w_at_end;
    logic              w_over;
    logic              w_done;
    logic              w_can_go;

    assign w_ix     = r_idx[IDX_W-1:0];
    assign w_eid    = r_ids[w_ix];
    assign w_erem   = r_rem[w_ix];
    assign w_earm   = r_arm[w_ix];
    assign w_at_end = (r_idx == r_count);
    assign w_over   = (r_cmd.duration > (TIME_MAX - r_world));
    assign w_done   = (r_state == S_UPDATE) && !w_at_end && w_earm && (w_erem == r_min);
    assign w_can_go = !r_pend || i_res_ready;

    assign o_cmd_take  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EMIT) || (r_state == S_FLUSH) ||
                         (w_done && r_pend);

    always_comb begin
        o_res.world_time = r_world;
        case (r_state)
            S_UPDATE: begin
                o_res.status          = ST_OK;
                o_res.step_secs       = r_min;
                o_res.idle_cnt        = '0;
                o_res.completed_valid = 1'b1;
                o_res.completed_id    = r_pid;
                o_res.last            = 1'b0;
            end
            S_FLUSH: begin
                o_res.status          = ST_OK;
                o_res.step_secs       = r_min;
                o_res.idle_cnt        = '0;
                o_res.completed_valid = r_pend;
                o_res.completed_id    = r_pend ? r_pid : '0;
                o_res.last            = 1'b1;
            end
            default: begin
                o_res.status          = r_status;
                o_res.step_secs       = '0;
                o_res.idle_cnt        = r_wcnt;
                o_res.completed_valid = 1'b0;
                o_res.completed_id    = '0;
                o_res.last            = 1'b1;
            end
        endcase
    end

    // ids need no reset: only entries below the count are read
    always_ff @(posedge i_clk) begin
        if (r_state == S_INSERT) begin
            for (int j = 0; j < MAX_ENTRIES; j++) begin
                if (IDX_W'(j) == r_slot) begin
                    r_ids[j] <= r_cmd.entry_id;
                end else if (j > 0 && CNT_W'(j) > CNT_W'(r_slot) &&
                             CNT_W'(j) <= r_count) begin
                    r_ids[j] <= r_ids[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_world <= '0;
            r_pend  <= 1'b0;
            for (int j = 0; j < MAX_ENTRIES; j++) begin
                r_arm[j] <= 1'b0;
                r_rem[j] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_idx    <= '0;
                    r_pend   <= 1'b0;
                    r_wait   <= '0;
                    r_wcnt   <= '0;
                    r_status <= ST_REJ;
                    case (r_cmd.kind)
                        K_ADD: begin
                            if (!(r_cmd.bad || r_cmd.entry_id == '0 ||
                                  r_count >= CNT_W'(MAX_ENTRIES) || r_world != '0)) begin
                                r_state <= S_SCAN;
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end
                        K_BOOK: begin
                            if (!(r_cmd.bad || w_over)) r_state <= S_SCAN;
                            else r_state <= S_EMIT;
                        end
                        K_NEXT: begin
                            r_min <= TIME_MAX;
                            if (r_count != '0) r_state <= S_SCAN;
                            else r_state <= S_EMIT;
                        end
                        default: begin
                            r_min <= r_cmd.duration;
                            if (!(r_cmd.bad || w_over)) r_state <= S_SCAN;
                            else r_state <= S_EMIT;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (w_at_end) begin
                        case (r_cmd.kind)
                            K_ADD: begin
                                r_slot  <= w_ix;
                                r_state <= S_INSERT;
                            end
                            K_BOOK: begin
                                r_status <= ST_REJ;
                                r_state  <= S_EMIT;
                            end
                            K_NEXT: begin
                                if (r_wait != '0) begin
                                    r_status <= ST_WAIT;
                                    r_wcnt   <= WAIT_W'(r_wait);
                                    r_state  <= S_EMIT;
                                end else if (r_min > (TIME_MAX - r_world)) begin
                                    r_status <= ST_REJ;
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_world <= r_world + r_min;
                                    r_idx   <= '0;
                                    r_state <= S_UPDATE;
                                end
                            end
                            default: begin
                                r_world <= r_world + r_min;
                                r_idx   <= '0;
                                r_state <= S_UPDATE;
                            end
                        endcase
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                        case (r_cmd.kind)
                            K_ADD: begin
                                if (w_eid == r_cmd.entry_id) begin
                                    r_status <= ST_REJ;
                                    r_state  <= S_EMIT;
                                end else if (w_eid > r_cmd.entry_id) begin
                                    r_slot  <= w_ix;
                                    r_state <= S_INSERT;
                                end
                            end
                            K_BOOK: begin
                                if (w_eid == r_cmd.entry_id) begin
                                    if (w_earm) begin
                                        r_status <= ST_REJ;
                                    end else begin
                                        r_arm[w_ix] <= 1'b1;
                                        r_rem[w_ix] <= r_cmd.duration;
                                        r_status    <= ST_OK;
                                    end
                                    r_state <= S_EMIT;
                                end
                            end
                            K_NEXT: begin
                                if (!w_earm) r_wait <= r_wait + CNT_W'(1);
                                else if (w_erem < r_min) r_min <= w_erem;
                            end
                            default: begin
                                if (w_earm && w_erem < r_min) r_min <= w_erem;
                            end
                        endcase
                    end
                end
                S_INSERT: begin
                    for (int j = 0; j < MAX_ENTRIES; j++) begin
                        if (IDX_W'(j) == r_slot) begin
                            r_arm[j] <= 1'b0;
                            r_rem[j] <= '0;
                        end else if (j > 0 && CNT_W'(j) > CNT_W'(r_slot) &&
                                     CNT_W'(j) <= r_count) begin
                            r_arm[j] <= r_arm[j-1];
                            r_rem[j] <= r_rem[j-1];
                        end
                    end
                    r_count  <= r_count + CNT_W'(1);
                    r_status <= ST_OK;
                    r_state  <= S_EMIT;
                end
                S_UPDATE: begin
                    if (w_at_end) begin
                        r_state <= S_FLUSH;
                    end else if (w_done) begin
                        // hold the newest completion back so the final one gets last
                        if (w_can_go) begin
                            r_arm[w_ix] <= 1'b0;
                            r_rem[w_ix] <= '0;
                            r_pend      <= 1'b1;
                            r_pid       <= w_eid;
                            r_idx       <= r_idx + CNT_W'(1);
                        end
                    end else begin
                        if (w_earm) r_rem[w_ix] <= w_erem - r_min;
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_FLUSH, S_EMIT: begin
                    if (i_res_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table size");
    a_step_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> (r_min != '0))
        else $error("zero time step in update pass");
    a_world_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |=> (r_world == $past(r_world)) || ($past(r_state) == S_SCAN))
        else $error("world time moved outside the scan end");
`endif

endmodule

// ===== hw/rtl/scs_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_out_fifo
// Two-deep result queue between the sequencer and the result ports.
// ----------------------------------------------------------------------------
module scs_out_fifo import scs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_res i_res,
    output logic o_ready,
    output logic empty,
    input  logic pop,
    output t_res o_res
);

    t_res       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign empty   = (r_cnt == 2'd0);
    assign o_res   = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ===== hw/rtl/shared_countdown_scheduler.sv =====
`timescale 1ns / 1ps
// Sequencer steps: add decides, scans for the slot, inserts and emits; book and
//   waiting decide, scan and emit; field or empty-table rejects decide and emit;
//   advance/tick decide, scan once for the minimum, update once and flush.
// Flow: one item at a time in the sequencer; a full result queue stalls the
//   sequencer.
// Reset: synchronous active low; clears entry timers and flags, count, world time and queues.
// ----------------------------------------------------------------------------
// shared_countdown_scheduler
// Sorted participant table with countdown timers and a shared world time.
// ----------------------------------------------------------------------------
module shared_countdown_scheduler import scs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_kind,
    input  logic [ID_W-1:0]   i_entry_id,
    input  logic [2:0]        i_activity,
    input  logic [TIME_W-1:0] i_duration,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        o_status,
    output logic [TIME_W-1:0] o_step_secs,
    output logic [TIME_W-1:0] o_world_time,
    output logic [WAIT_W-1:0] o_idle_cnt,
    output logic              o_completed_valid,
    output logic [ID_W-1:0]   o_completed_id,
    output logic              o_last
);

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_take;
    logic w_res_valid;
    t_res w_res;
    logic w_res_ready;
    t_res w_head;

    scs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_kind      (i_kind),
        .i_entry_id  (i_entry_id),
        .i_activity  (i_activity),
        .i_duration  (i_duration),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    scs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    scs_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_res   (w_res),
        .o_ready (w_res_ready),
        .empty   (empty),
        .pop     (pop),
        .o_res   (w_head)
    );

    assign o_status          = w_head.status;
    assign o_step_secs       = w_head.step_secs;
    assign o_world_time      = w_head.world_time;
    assign o_idle_cnt        = w_head.idle_cnt;
    assign o_completed_valid = w_head.completed_valid;
    assign o_completed_id    = w_head.completed_id;
    assign o_last            = w_head.last;

endmodule

// ===== sim/scs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_checker
// Watches both queues of the countdown scheduler, keeps a shadow copy of the
// participant table and world time, and compares each popped result with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module scs_checker import scs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [1:0]        i_kind,
    input  logic [ID_W-1:0]   i_entry_id,
    input  logic [2:0]        i_activity,
    input  logic [TIME_W-1:0] i_duration,
    input  logic              empty,
    input  logic              pop,
    input  logic [1:0]        o_status,
    input  logic [TIME_W-1:0] o_step_secs,
    input  logic [TIME_W-1:0] o_world_time,
    input  logic [WAIT_W-1:0] o_idle_cnt,
    input  logic              o_completed_valid,
    input  logic [ID_W-1:0]   o_completed_id,
    input  logic              o_last,
    output int                o_fail_count,
    output int                o_pending
);

    logic [ID_W-1:0]   tbl_id [MAX_ENTRIES];
    logic [TIME_W-1:0] tbl_left [MAX_ENTRIES];
    logic              tbl_armed [MAX_ENTRIES];
    int                tbl_n;
    logic [TIME_W-1:0] now_s;
    t_res              expected_q[$];

    assign o_pending = expected_q.size();

    function automatic t_res mk_res(logic [1:0] st, logic [TIME_W-1:0] adv,
                                    logic [WAIT_W-1:0] wc, logic cv,
                                    logic [ID_W-1:0] cid, logic lst);
        t_res r;
        r.status = st;
        r.step_secs = adv;
        r.world_time = now_s;
        r.idle_cnt = wc;
        r.completed_valid = cv;
        r.completed_id = cid;
        r.last = lst;
        return r;
    endfunction

    task automatic run_clock(logic [TIME_W-1:0] secs);
        logic [TIME_W-1:0] step;
        logic [ID_W-1:0]   done[$];
        step = secs;
        if (secs == 0 || secs > TIME_MAX - now_s) begin
            expected_q.push_back(mk_res(ST_REJ, '0, '0, 1'b0, '0, 1'b1));
            return;
        end
        for (int i = 0; i < tbl_n; i++)
            if (tbl_armed[i] && tbl_left[i] < step) step = tbl_left[i];
        now_s += step;
        for (int i = 0; i < tbl_n; i++) begin
            if (!tbl_armed[i]) continue;
            tbl_left[i] -= step;
            if (tbl_left[i] == 0) begin
                done.push_back(tbl_id[i]);
                tbl_armed[i] = 1'b0;
            end
        end
        if (done.size() == 0)
            expected_q.push_back(mk_res(ST_OK, step, '0, 1'b0, '0, 1'b1));
        foreach (done[k])
            expected_q.push_back(mk_res(ST_OK, step, '0, 1'b1, done[k],
                                        k == done.size() - 1));
    endtask

    task automatic predict_item(logic [1:0] kind, logic [ID_W-1:0] id,
                                logic [2:0] act, logic [TIME_W-1:0] dur);
        int slot;
        int idle;
        logic [TIME_W-1:0] soonest;
        slot = 0;
        idle = 0;
        soonest = TIME_MAX;
        case (kind)
            K_ADD: begin
                while (slot < tbl_n && tbl_id[slot] < id) slot++;
                if (id == 0 || tbl_n >= MAX_ENTRIES || now_s != 0 ||
                    (slot < tbl_n && tbl_id[slot] == id)) begin
                    expected_q.push_back(mk_res(ST_REJ, '0, '0, 1'b0, '0, 1'b1));
                end else begin
                    for (int i = tbl_n; i > slot; i--) begin
                        tbl_id[i] = tbl_id[i-1];
                        tbl_left[i] = tbl_left[i-1];
                        tbl_armed[i] = tbl_armed[i-1];
                    end
                    tbl_id[slot] = id;
                    tbl_left[slot] = '0;
                    tbl_armed[slot] = 1'b0;
                    tbl_n++;
                    expected_q.push_back(mk_res(ST_OK, '0, '0, 1'b0, '0, 1'b1));
                end
            end
            K_BOOK: begin
                slot = -1;
                if (!(act == 0 || act > ACTIVITY_MAX || dur == 0 ||
                      dur > TIME_MAX - now_s))
                    for (int i = 0; i < tbl_n; i++)
                        if (tbl_id[i] == id && !tbl_armed[i]) slot = i;
                if (slot >= 0) begin
                    tbl_left[slot] = dur;
                    tbl_armed[slot] = 1'b1;
                    expected_q.push_back(mk_res(ST_OK, '0, '0, 1'b0, '0, 1'b1));
                end else begin
                    expected_q.push_back(mk_res(ST_REJ, '0, '0, 1'b0, '0, 1'b1));
                end
            end
            K_NEXT: begin
                for (int i = 0; i < tbl_n; i++) begin
                    if (!tbl_armed[i]) idle++;
                    else if (tbl_left[i] < soonest) soonest = tbl_left[i];
                end
                if (tbl_n == 0)
                    expected_q.push_back(mk_res(ST_REJ, '0, '0, 1'b0, '0, 1'b1));
                else if (idle > 0)
                    expected_q.push_back(mk_res(ST_WAIT, '0, WAIT_W'(idle), 1'b0,
                                                '0, 1'b1));
                else
                    run_clock(soonest);
            end
            default: run_clock(dur);
        endcase
    endtask

    task automatic check_field(string name, logic [TIME_W-1:0] exp_v,
                               logic [TIME_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            tbl_n = 0;
            now_s = '0;
            o_fail_count = 0;
            expected_q.delete();
            for (int i = 0; i < MAX_ENTRIES; i++) tbl_armed[i] = 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_q.size() == 0) begin
                    $error("result popped with nothing expected");
                    o_fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    check_field("status", TIME_W'(e.status), TIME_W'(o_status));
                    check_field("step_secs", e.step_secs, o_step_secs);
                    check_field("world_time", e.world_time, o_world_time);
                    check_field("idle_cnt", TIME_W'(e.idle_cnt), TIME_W'(o_idle_cnt));
                    check_field("completed_valid", TIME_W'(e.completed_valid),
                                TIME_W'(o_completed_valid));
                    check_field("completed_id", TIME_W'(e.completed_id),
                                TIME_W'(o_completed_id));
                    check_field("last", TIME_W'(e.last), TIME_W'(o_last));
                end
            end
            // prediction after the pop check so a same-edge result is never
            // compared against this item's expectation
            if (push && !full) predict_item(i_kind, i_entry_id, i_activity, i_duration);
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives add/book/advance/tick sequences into the countdown scheduler with
// random gaps and pop stalls, including a long pop hold-off; the checker
// does the comparison.
// ----------------------------------------------------------------------------
module tb;
    import scs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic [1:0]        i_kind;
    logic [ID_W-1:0]   i_entry_id;
    logic [2:0]        i_activity;
    logic [TIME_W-1:0] i_duration;
    logic              empty;
    logic              pop;
    logic [1:0]        o_status;
    logic [TIME_W-1:0] o_step_secs;
    logic [TIME_W-1:0] o_world_time;
    logic [WAIT_W-1:0] o_idle_cnt;
    logic              o_completed_valid;
    logic [ID_W-1:0]   o_completed_id;
    logic              o_last;
    int                fail_count;
    int                pending;
    int                idle_cycles;
    bit                calm;
    bit                stim_done;
    bit                hold_pop;
    logic [ID_W-1:0]   known_ids[$];

    shared_countdown_scheduler u_top (.*);

    scs_checker u_chk (.*, .o_fail_count(fail_count), .o_pending(pending));

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic send(logic [1:0] kind, logic [ID_W-1:0] id, logic [2:0] act,
                        logic [TIME_W-1:0] dur);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_kind <= kind;
        i_entry_id <= id;
        i_activity <= act;
        i_duration <= dur;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom(), $urandom()} >> $urandom_range(0, 62));
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if (known_ids.size() > 0 && $urandom_range(0, 9) != 0)
            return known_ids[$urandom_range(0, known_ids.size() - 1)];
        return $urandom();
    endfunction

    // add entries and book each, then mix advances, ticks, books and random kinds
    task automatic session(int adds);
        logic [ID_W-1:0] id;
        known_ids.delete();
        for (int i = 0; i < adds; i++) begin
            id = ($urandom_range(0, 1)) ? $urandom() : $urandom_range(1, 40);
            known_ids.push_back(id);
            send(K_ADD, id, '0, '0);
        end
        foreach (known_ids[i])
            send(K_BOOK, known_ids[i], 3'($urandom_range(1, 7)),
                 ($urandom_range(0, 2) == 0) ? rand_time() :
                                               TIME_W'($urandom_range(1, 6)));
        for (int i = 0; i < 2 * adds; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send(K_NEXT, $urandom(), 3'($urandom()), rand_time());
                4, 5: send(K_TICK, $urandom(), 3'($urandom()),
                           TIME_W'($urandom_range(0, 5)));
                6, 7: send(K_BOOK, pick_id(), 3'($urandom()),
                           TIME_W'($urandom_range(0, 8)));
                8: send(K_BOOK, pick_id(), 3'($urandom()), rand_time());
                default: send(2'($urandom()), pick_id(), 3'($urandom()), rand_time());
            endcase
        end
    endtask

    initial begin
        int phase_items;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_kind = K_ADD;
        i_entry_id = '0;
        i_activity = '0;
        i_duration = '0;
        calm = 1'b0;
        stim_done = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: empty table cases, rejects, booking limits at world time zero
        send(K_NEXT, '0, '0, '0);
        send(K_TICK, '0, '0, '0);
        send(K_ADD, '0, '0, '0);
        send(K_ADD, '1, '0, '0);
        send(K_ADD, 32'd1, '0, '0);
        send(K_ADD, 32'd1, '0, '0);
        send(K_NEXT, '0, '0, '0);
        send(K_BOOK, 32'd1, 3'd0, 63'd5);
        send(K_BOOK, 32'd1, 3'd7, 63'd0);
        send(K_BOOK, 32'd2, 3'd1, 63'd5);
        send(K_BOOK, '1, 3'd7, TIME_MAX);
        send(K_BOOK, 32'd1, 3'd1, 63'd3);
        send(K_BOOK, 32'd1, 3'd1, 63'd3);
        // adds only work while world time is zero, so add the entries first
        session(14);
        phase_items = 0;
        while (phase_items < 204) begin
            // re-arm idle entries with short durations to hit many completions
            send(K_BOOK, pick_id(), 3'($urandom_range(0, 7)),
                 TIME_W'($urandom_range(0, 4)));
            send(K_BOOK, pick_id(), 3'($urandom_range(1, 7)),
                 TIME_W'($urandom_range(1, 4)));
            case ($urandom_range(0, 3))
                0: send(K_ADD, $urandom(), 3'($urandom()), rand_time());
                1: send(K_TICK, $urandom(), 3'($urandom()), rand_time());
                default: send(K_NEXT, $urandom(), 3'($urandom()), rand_time());
            endcase
            phase_items += 3;
            if (phase_items > 160) calm = 1'b1;
        end
        // world time limits
        send(K_ADD, 32'd9, '0, '0);
        send(K_TICK, '0, '0, 63'd1);
        send(K_TICK, '0, '0, TIME_MAX);
        send(K_TICK, '0, '0, TIME_MAX - 63'd4);
        send(K_BOOK, 32'd1, 3'd2, 63'd5);
        send(K_TICK, '0, '0, 63'd2);
        push <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls plus one long hold-off while items keep coming
    initial begin
        int pops;
        pop = 1'b0;
        hold_pop = 1'b0;
        pops = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!empty && pop) pops++;
            if (pops == 10 && !hold_pop) begin
                hold_pop = 1'b1;
                pop <= 1'b0;
                repeat (600) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            pop <= 1'b1;
        end
    end

    initial begin
        idle_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (stim_done && pending == 0) begin
                repeat (100) @(posedge i_clk);
                if (fail_count == 0) $display("*** PASSED ***");
                else $display("*** FAILED ***");
                $finish;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
hw/rtl/scs_pkg.sv
hw/rtl/scs_front.sv
hw/rtl/scs_back.sv
hw/rtl/scs_out_fifo.sv
hw/rtl/shared_countdown_scheduler.sv
sim/scs_checker.sv
sim/tb.sv
